// ===== rtl/core/ilm_pkg.sv =====
// shared types and constants for the in-flight i/o latency monitor
// no dependencies

package ilm_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_ENABLE   = 2'd0;
  localparam logic [1:0] CFG_CRIT_THR = 2'd1;
  localparam logic [1:0] CFG_WARN_THR = 2'd2;

  localparam logic OP_ISSUE    = 1'b0;
  localparam logic OP_COMPLETE = 1'b1;

  typedef struct packed {
    logic [11:0] major;
    logic [19:0] minor;
    logic [47:0] sector;
    logic [22:0] count;
    logic        dir;
  } key_t;

  typedef struct packed {
    logic [47:0] issue_time;
    logic [47:0] cgroup;
    logic [21:0] pid;
    logic        ambiguous;
  } data_t;

  localparam int KEY_W  = $bits(key_t);
  localparam int DATA_W = $bits(data_t);

  typedef enum logic [1:0] {
    MODE_TOUCH = 2'd0,
    MODE_ALLOC = 2'd1,
    MODE_FREE  = 2'd2
  } upd_mode_t;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SCAN = 6'b000010,
    ST_LAT  = 6'b000100,
    ST_SEV  = 6'b001000,
    ST_UPD  = 6'b010000,
    ST_EMIT = 6'b100000
  } state_t;

endpackage

// ===== rtl/core/ilm_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies

module ilm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/inflight_io_latency_monitor.sv =====
// in-flight block i/o latency monitor: lru request table held in one ram
// depends on ilm_pkg and ilm_ram
//
// an ignored beat (other direction, or issue while disabled) leaves the block
// idle; an issue runs one search pass and then one age/write-back pass over the
// single-read-port table ram, an unmatched completion runs only the search pass,
// and a matched completion runs the search pass, the latency and severity steps
// and the write-back pass that frees its entry, then emits any result it leaves.
// the next beat is taken once the table is written back and any
// result sits in the output register (a stalled earlier result adds its wait).
// reset (rst_n low, synchronous) clears valid bits, counters, config and
// handshake state; the table ram itself is never cleared

module inflight_io_latency_monitor #(
  parameter int ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data,
  // input beats
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [1:0]  in_direction,
  input  logic [11:0] in_dev_major,
  input  logic [19:0] in_dev_minor,
  input  logic [47:0] in_sector,
  input  logic [22:0] in_sector_count,
  input  logic [47:0] in_now_ns,
  input  logic [47:0] in_cgroup,
  input  logic [21:0] in_process_id,
  input  logic signed [12:0] in_error,
  // result beats
  output logic        out_valid,
  input  logic        out_stall,
  output logic [47:0] out_stamp_ns,
  output logic [47:0] out_delay_ns,
  output logic [47:0] out_cgroup,
  output logic [47:0] out_sector,
  output logic [11:0] out_major,
  output logic [19:0] out_minor,
  output logic [31:0] out_byte_count,
  output logic [21:0] out_pid,
  output logic signed [12:0] out_error,
  output logic        out_direction,
  output logic        out_severity,
  output logic [31:0] out_ambiguous_total
);
  import ilm_pkg::*;

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int WW = AW + DATA_W + KEY_W;
  localparam logic [CW-1:0] LAST_CNT = CW'(ENTRIES);

  // configuration registers
  logic        enable_r;
  logic [47:0] crit_r;
  logic [47:0] warn_r;

  // captured beat
  logic        op_r;
  key_t        key_r;
  logic [47:0] now_r;
  logic [47:0] cg_r;
  logic [21:0] pid_r;
  logic signed [12:0] err_r;

  state_t state_r, state_nxt;

  // pass sequencing over the ram
  logic [CW-1:0] cnt_r;
  logic          rvld_r;
  logic [AW-1:0] ridx_r;

  // search results
  logic          hit_r;
  logic [AW-1:0] hit_idx_r;
  logic [AW-1:0] hit_age_r;
  data_t         hit_data_r;
  logic          free_r;
  logic [AW-1:0] free_idx_r;
  logic [AW-1:0] lru_idx_r;
  logic [AW-1:0] lru_age_r;

  upd_mode_t     mode_r;
  logic [AW-1:0] tgt_idx_r;
  logic [47:0]   lat_r;
  logic          emit_r;
  logic          sev_r;
  logic [31:0]   amb_cnt_r;

  logic [ENTRIES-1:0] valid_r;

  // ram ports
  logic          ram_we;
  logic [WW-1:0] ram_wdata;
  logic [WW-1:0] ram_rdata;
  logic          rd_issue;

  key_t          rkey;
  data_t         rdat;
  data_t         amb_dat;
  data_t         new_dat;
  logic [AW-1:0] rage;
  logic [AW-1:0] age_adj;
  logic          rvalid;
  logic          pass_done;
  logic          in_accept;
  logic          ignore_beat;
  logic          crit_hit;
  logic          warn_hit;
  logic          out_free;

  ilm_ram #(
    .WIDTH (WW),
    .DEPTH (ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ridx_r),
    .wdata (ram_wdata),
    .raddr (cnt_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  // unpack the word from the registered ram read port
  assign rkey   = key_t'(ram_rdata[KEY_W-1:0]);
  assign rdat   = data_t'(ram_rdata[KEY_W +: DATA_W]);
  assign rage   = ram_rdata[KEY_W+DATA_W +: AW];
  assign rvalid = valid_r[ridx_r];

  assign in_stall    = (state_r != ST_IDLE);
  assign in_accept   = in_valid && !in_stall;
  assign ignore_beat = in_direction[1] || ((in_op == OP_ISSUE) && !enable_r);
  assign rd_issue    = ((state_r == ST_SCAN) || (state_r == ST_UPD)) && (cnt_r != LAST_CNT);
  assign pass_done   = (cnt_r == LAST_CNT) && !rvld_r;
  assign out_free    = !out_valid || !out_stall;

  // age adjustment for entries other than the target
  always_comb begin
    age_adj = rage;
    unique case (mode_r)
      MODE_TOUCH: if (rage < hit_age_r) age_adj = rage + AW'(1);
      MODE_ALLOC: age_adj = rage + AW'(1);
      MODE_FREE:  if (rage > hit_age_r) age_adj = rage - AW'(1);
      default:    age_adj = rage;
    endcase
  end

  always_comb begin
    amb_dat           = rdat;
    amb_dat.ambiguous = 1'b1;
    new_dat.issue_time = now_r;
    new_dat.cgroup     = cg_r;
    new_dat.pid        = pid_r;
    new_dat.ambiguous  = 1'b0;
  end

  // write-back during the second pass
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = {age_adj, rdat, rkey};
    if ((state_r == ST_UPD) && rvld_r) begin
      if (ridx_r == tgt_idx_r) begin
        ram_we = (mode_r != MODE_FREE);
        if (mode_r == MODE_ALLOC) begin
          ram_wdata = {AW'(0), new_dat, key_r};
        end else begin
          ram_wdata = {AW'(0), amb_dat, rkey};
        end
      end else begin
        ram_we = rvalid;
      end
    end
  end

  assign crit_hit = (crit_r != '0) && (lat_r >= crit_r);
  assign warn_hit = (warn_r != '0) && (lat_r >= warn_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_accept && !ignore_beat) state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (pass_done) begin
          priority if (op_r == OP_ISSUE) state_nxt = ST_UPD;
          else if (hit_r)                state_nxt = ST_LAT;
          else                           state_nxt = ST_IDLE;
        end
      end
      ST_LAT:  state_nxt = ST_SEV;
      ST_SEV:  state_nxt = ST_UPD;
      ST_UPD: begin
        if (pass_done) begin
          state_nxt = ((mode_r == MODE_FREE) && emit_r) ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      enable_r  <= 1'b0;
      crit_r    <= '0;
      warn_r    <= '0;
      valid_r   <= '0;
      amb_cnt_r <= '0;
      rvld_r    <= 1'b0;
      cnt_r     <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_ENABLE:   enable_r <= cfg_data[0];
          CFG_CRIT_THR: crit_r   <= cfg_data;
          CFG_WARN_THR: warn_r   <= cfg_data;
          default: ;
        endcase
      end

      // read pipeline shared by both passes
      rvld_r <= rd_issue;
      ridx_r <= cnt_r[AW-1:0];
      if (rd_issue) cnt_r <= cnt_r + CW'(1);

      unique case (state_r)
        ST_IDLE: begin
          cnt_r     <= '0;
          hit_r     <= 1'b0;
          free_r    <= 1'b0;
          lru_age_r <= '0;
          lru_idx_r <= '0;
          if (in_accept) begin
            op_r         <= in_op;
            key_r.major  <= in_dev_major;
            key_r.minor  <= in_dev_minor;
            key_r.sector <= in_sector;
            key_r.count  <= in_sector_count;
            key_r.dir    <= in_direction[0];
            now_r        <= in_now_ns;
            cg_r         <= in_cgroup;
            pid_r        <= in_process_id;
            err_r        <= in_error;
          end
        end
        ST_SCAN: begin
          if (rvld_r) begin
            if (rvalid && (rkey == key_r)) begin
              hit_r      <= 1'b1;
              hit_idx_r  <= ridx_r;
              hit_age_r  <= rage;
              hit_data_r <= rdat;
            end
            // ages of live entries are distinct, the oldest is the lru
            if (rvalid && (rage >= lru_age_r)) begin
              lru_age_r <= rage;
              lru_idx_r <= ridx_r;
            end
            if (!rvalid && !free_r) begin
              free_r     <= 1'b1;
              free_idx_r <= ridx_r;
            end
          end
          if (pass_done) begin
            cnt_r <= '0;
            if (op_r == OP_ISSUE) begin
              mode_r    <= hit_r ? MODE_TOUCH : MODE_ALLOC;
              tgt_idx_r <= hit_r ? hit_idx_r : (free_r ? free_idx_r : lru_idx_r);
            end else begin
              mode_r    <= MODE_FREE;
              tgt_idx_r <= hit_idx_r;
            end
            emit_r <= 1'b0;
          end
        end
        ST_LAT: lat_r <= now_r - hit_data_r.issue_time;
        ST_SEV: begin
          emit_r <= enable_r && !hit_data_r.ambiguous
                    && ((err_r != '0) || crit_hit || warn_hit);
          sev_r  <= (err_r != '0) || crit_hit;
          if (enable_r && hit_data_r.ambiguous) amb_cnt_r <= amb_cnt_r + 32'd1;
        end
        ST_UPD: begin
          if (pass_done) begin
            if (mode_r == MODE_ALLOC) valid_r[tgt_idx_r] <= 1'b1;
            if (mode_r == MODE_FREE)  valid_r[tgt_idx_r] <= 1'b0;
          end
        end
        ST_EMIT: ;
        default: ;
      endcase

      // output register, loaded only once the previous beat has gone
      if ((state_r == ST_EMIT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_EMIT) && out_free) begin
      out_stamp_ns        <= now_r;
      out_delay_ns        <= lat_r;
      out_cgroup          <= hit_data_r.cgroup;
      out_sector          <= key_r.sector;
      out_major           <= key_r.major;
      out_minor           <= key_r.minor;
      out_byte_count      <= {key_r.count, 9'd0};
      out_pid             <= hit_data_r.pid;
      out_error           <= err_r;
      out_direction       <= key_r.dir;
      out_severity        <= sev_r;
      out_ambiguous_total <= amb_cnt_r;
    end
  end

endmodule

// ===== rtl/core/ilm_checker.sv =====
// port-level checks for the in-flight i/o latency monitor
// depends on the top level's ports; bound to it below

module ilm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [47:0] out_delay_ns,
  input logic signed [12:0] out_error,
  input logic        out_severity
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_delay_ns))
    else $error("result beat changed under stall");

  // an error always reports as critical
  a_err_crit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_error != 13'sd0) |-> out_severity)
    else $error("error result not critical");

  // a result never appears the cycle after an input beat is taken
  a_no_fast_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result too soon after input beat");

  // reset leaves no result pending and the input open
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("reset state wrong");

endmodule

bind inflight_io_latency_monitor ilm_checker u_ilm_checker (.*);
